// File: sv/periodic_lattice_neighbors_core_defines.svh
// Assertion shorthands for the checks in the core module of this block.
// Every check is clocked on clk_i and is switched off while rst_ni is low.
`ifndef PERIODIC_LATTICE_NEIGHBORS_CORE_DEFINES_SVH
`define PERIODIC_LATTICE_NEIGHBORS_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lpn_pkg.sv
`default_nettype none

package lpn_pkg;

  // Field widths.
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned SIDE_W    = 9;
  localparam int unsigned SITES_W   = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = SITES_W;

  // Neighbor slots: six on the triangular lattice, four on the square one.
  localparam int unsigned NBR_N  = 6;
  localparam int unsigned NBR_SQ = 4;
  localparam int unsigned MODE_N = 2;

  // Signed offsets reach two side lengths, raw neighbor values one volume
  // plus that; magnitudes drop the sign bit.
  localparam int unsigned OFF_W = SIDE_W + 2;
  localparam int unsigned RAW_W = IDX_W + 2;
  localparam int unsigned MAG_W = RAW_W - 1;

  // Pipeline shape: remainder by side length, neighbor arithmetic,
  // remainder by site count, output register.
  localparam int unsigned DIV_STAGES  = 4;
  localparam int unsigned WRAP_STAGES = 3;
  localparam int unsigned PIPE_DEPTH  = DIV_STAGES + WRAP_STAGES + 2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SITE_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LATTICE_MODE = 2'd2;

  // Lattice modes.
  localparam logic MODE_SQUARE = 1'b0;
  localparam logic MODE_TRI    = 1'b1;

  // Reset values of the registers.
  localparam logic [SIDE_W-1:0]  SIDE_RST  = 9'd16;
  localparam logic [SITES_W-1:0] SITES_RST = 17'd256;
  localparam logic               MODE_RST  = MODE_SQUARE;

  // Effective geometry seen by the neighbor arithmetic.
  typedef struct packed {
    logic [SIDE_W-1:0] side;
    logic              tri_mode;
  } lpn_geom_t;

  // Side information that rides along the side-length remainder.
  typedef struct packed {
    logic             err;
    logic [IDX_W-1:0] site;
  } lpn_site_sb_t;

  // Side information that rides along the site-count remainder.
  typedef struct packed {
    logic             err;
    logic [NBR_N-1:0] neg;
  } lpn_wrap_sb_t;

endpackage

`default_nettype wire

// File: sv/periodic_lattice_neighbors_core.sv
`default_nettype none
`include "periodic_lattice_neighbors_core_defines.svh"

// Nearest-neighbor index generator for a periodic two-dimensional lattice
// numbered row by row. Each input word is a site index; each output word
// carries its right, up(-right), up/left, ... neighbors (four in square mode,
// six in triangular mode, unused slots zero) and an error flag for a site at
// or beyond the site count, in which case all neighbors read zero. The block
// takes one word per clock unless the output stalls. Four stages reduce
// the site index modulo the side length (four bits per stage), one stage
// forms the neighbor offsets, three stages reduce each neighbor modulo the
// site count (six bits per stage), and one output register holds the result.
// Every stage has its own valid bit, so bubbles close up while the output is
// stalled. The user must see that registers are written through the plain
// write port only while no word is in flight; the block does not enforce it.
module periodic_lattice_neighbors_core #(
  parameter int unsigned MAX_SIDE  = 256,
  parameter int unsigned MAX_SITES = 65536
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [lpn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lpn_pkg::CFG_W-1:0]      cfg_data_i,
  // Input channel.
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lpn_pkg::IDX_W-1:0]      site_index_i,
  // Output channel.
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lpn_pkg::IDX_W-1:0]      neighbor_right_o,
  output logic [lpn_pkg::IDX_W-1:0]      neighbor_slot_one_o,
  output logic [lpn_pkg::IDX_W-1:0]      neighbor_slot_two_o,
  output logic [lpn_pkg::IDX_W-1:0]      neighbor_slot_three_o,
  output logic [lpn_pkg::IDX_W-1:0]      neighbor_slot_four_o,
  output logic [lpn_pkg::IDX_W-1:0]      neighbor_slot_five_o,
  output logic                           site_error_o
);

  import lpn_pkg::*;

  logic [SIDE_W-1:0]                 side_q;
  logic [SITES_W-1:0]                sites_q;
  logic                              mode_q;

  logic [SIDE_W-1:0]                 side_eff;
  logic [SITES_W-1:0]                sites_eff;
  lpn_geom_t                         geom;

  logic [PIPE_DEPTH-1:0]             vld_q;
  logic [PIPE_DEPTH-1:0]             vld_d;
  logic [PIPE_DEPTH-1:0]             vld_in;
  logic [PIPE_DEPTH-1:0]             rdy;

  lpn_site_sb_t                      site_sb_in;
  lpn_site_sb_t                      site_sb;
  logic [0:0][SIDE_W-1:0]            side_rem;
  logic [NBR_N-1:0][MAG_W-1:0]       mag;
  lpn_wrap_sb_t                      wrap_sb_in;
  lpn_wrap_sb_t                      wrap_sb;
  logic [NBR_N-1:0][SITES_W-1:0]     vol_rem;
  logic [NBR_N-1:0][IDX_W-1:0]       nbr;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q  <= SIDE_RST;
      sites_q <= SITES_RST;
      mode_q  <= MODE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SIDE_LENGTH:  side_q  <= cfg_data_i[SIDE_W-1:0];
        CFG_SITE_COUNT:   sites_q <= cfg_data_i[SITES_W-1:0];
        CFG_LATTICE_MODE: mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective geometry: a zero side counts as one, both limits saturate.
  always_comb begin
    if (side_q == '0) begin
      side_eff = SIDE_W'(1);
    end else if (32'(side_q) > 32'(MAX_SIDE)) begin
      side_eff = SIDE_W'(MAX_SIDE);
    end else begin
      side_eff = side_q;
    end
    if (32'(sites_q) > 32'(MAX_SITES)) begin
      sites_eff = SITES_W'(MAX_SITES);
    end else begin
      sites_eff = sites_q;
    end
  end

  assign geom.side     = side_eff;
  assign geom.tri_mode = mode_q;

  // Stage handshake: a stage advances when it is empty or its successor
  // advances.
  always_comb begin
    rdy[PIPE_DEPTH-1] = !vld_q[PIPE_DEPTH-1] || out_ready_i;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign vld_in = {vld_q[PIPE_DEPTH-2:0], in_valid_i};
  assign vld_d  = (rdy & vld_in) | (~rdy & vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[PIPE_DEPTH-1];

  // Range check happens on entry; the site rides along the first remainder.
  assign site_sb_in.err  = ({1'b0, site_index_i} >= sites_eff);
  assign site_sb_in.site = site_index_i;

  lpn_mod_pipe #(
    .DW   (IDX_W),
    .VW   (SIDE_W),
    .NST  (DIV_STAGES),
    .LANES(1),
    .SW   ($bits(lpn_site_sb_t))
  ) u_side_mod (
    .clk_i(clk_i),
    .en_i (rdy[DIV_STAGES-1:0]),
    .div_i(side_eff),
    .dvd_i(site_index_i),
    .sb_i (site_sb_in),
    .rem_o(side_rem),
    .sb_o (site_sb)
  );

  lpn_nbr_calc u_nbr_calc (
    .clk_i (clk_i),
    .en_i  (rdy[DIV_STAGES]),
    .geom_i(geom),
    .site_i(site_sb),
    .rem_i (side_rem[0]),
    .mag_o (mag),
    .sb_o  (wrap_sb_in)
  );

  lpn_mod_pipe #(
    .DW   (MAG_W),
    .VW   (SITES_W),
    .NST  (WRAP_STAGES),
    .LANES(NBR_N),
    .SW   ($bits(lpn_wrap_sb_t))
  ) u_vol_mod (
    .clk_i(clk_i),
    .en_i (rdy[DIV_STAGES+WRAP_STAGES:DIV_STAGES+1]),
    .div_i(sites_eff),
    .dvd_i(mag),
    .sb_i (wrap_sb_in),
    .rem_o(vol_rem),
    .sb_o (wrap_sb)
  );

  lpn_wrap_out u_wrap_out (
    .clk_i  (clk_i),
    .en_i   (rdy[PIPE_DEPTH-1]),
    .sites_i(sites_eff),
    .rem_i  (vol_rem),
    .sb_i   (wrap_sb),
    .nbr_o  (nbr),
    .err_o  (site_error_o)
  );

  assign neighbor_right_o      = nbr[0];
  assign neighbor_slot_one_o   = nbr[1];
  assign neighbor_slot_two_o   = nbr[2];
  assign neighbor_slot_three_o = nbr[3];
  assign neighbor_slot_four_o  = nbr[4];
  assign neighbor_slot_five_o  = nbr[5];

  // Checks on the pipeline and the result words.
  `LPN_ASSERT_NOW(a_err_clears, out_valid_o && site_error_o, (nbr == '0), "error word has a nonzero neighbor")
  `LPN_ASSERT_NOW(a_square_unused, out_valid_o && (mode_q == MODE_SQUARE), (neighbor_slot_four_o == '0) && (neighbor_slot_five_o == '0), "square word fills an unused slot")
  `LPN_ASSERT_NOW(a_in_range, out_valid_o && !site_error_o, ({1'b0, neighbor_right_o} < sites_eff) && ({1'b0, neighbor_slot_five_o} < sites_eff), "neighbor at or beyond the site count")
  `LPN_ASSERT_NOW(a_full_stall, !in_ready_o, (&vld_q) && !out_ready_i, "input stalled with room in the pipeline")
  `LPN_ASSERT_NEXT(a_drain, vld_q[PIPE_DEPTH-2] && !vld_q[PIPE_DEPTH-1], out_valid_o, "word did not reach an empty output register")

endmodule

`default_nettype wire

// File: sv/lpn_mod_pipe.sv
`default_nettype none

// Pipelined restoring remainder: each lane's dividend is reduced modulo a
// shared divisor, a fixed number of dividend bits per register stage.
module lpn_mod_pipe #(
  parameter int unsigned DW    = 16,
  parameter int unsigned VW    = 9,
  parameter int unsigned NST   = 4,
  parameter int unsigned LANES = 1,
  parameter int unsigned SW    = 1
) (
  input  logic                        clk_i,
  input  logic [NST-1:0]              en_i,
  input  logic [VW-1:0]               div_i,
  input  logic [LANES-1:0][DW-1:0]    dvd_i,
  input  logic [SW-1:0]               sb_i,
  output logic [LANES-1:0][VW-1:0]    rem_o,
  output logic [SW-1:0]               sb_o
);

  localparam int unsigned SPS = (DW + NST - 1) / NST;
  localparam int unsigned PW  = NST * SPS;

  logic [NST-1:0][LANES-1:0][VW-1:0] rem_q;
  logic [NST-1:0][LANES-1:0][PW-1:0] dvd_q;
  logic [NST-1:0][SW-1:0]            sb_q;

  logic [NST-1:0][LANES-1:0][VW-1:0] rem_src;
  logic [NST-1:0][LANES-1:0][PW-1:0] dvd_src;
  logic [NST-1:0][SW-1:0]            sb_src;

  logic [NST-1:0][LANES-1:0][VW-1:0] rem_d;
  logic [NST-1:0][LANES-1:0][PW-1:0] dvd_d;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  function automatic logic [VW-1:0] rem_step(input logic [VW-1:0] r, input logic b,
                                             input logic [VW-1:0] d);
    logic [VW:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[VW-1:0];
  endfunction

  // Stage inputs: the first stage starts from a zero remainder.
  always_comb begin
    rem_src[0] = '0;
    for (int l = 0; l < LANES; l++) begin
      dvd_src[0][l] = PW'(dvd_i[l]);
    end
    sb_src[0] = sb_i;
    for (int s = 1; s < NST; s++) begin
      rem_src[s] = rem_q[s-1];
      dvd_src[s] = dvd_q[s-1];
      sb_src[s]  = sb_q[s-1];
    end
  end

  // Each stage consumes SPS dividend bits, most significant first.
  always_comb begin
    rem_d = rem_src;
    dvd_d = dvd_src;
    for (int s = 0; s < NST; s++) begin
      for (int l = 0; l < LANES; l++) begin
        for (int j = 0; j < SPS; j++) begin
          rem_d[s][l] = rem_step(rem_d[s][l], dvd_d[s][l][PW-1], div_i);
          dvd_d[s][l] = dvd_d[s][l] << 1;
        end
      end
    end
  end

  // Stage registers load whenever their stage may advance.
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NST; s++) begin
      if (en_i[s]) begin
        rem_q[s] <= rem_d[s];
        dvd_q[s] <= dvd_d[s];
        sb_q[s]  <= sb_src[s];
      end
    end
  end

  assign rem_o = rem_q[NST-1];
  assign sb_o  = sb_q[NST-1];

endmodule

`default_nettype wire

// File: sv/lpn_nbr_calc.sv
`default_nettype none

// Neighbor arithmetic: each neighbor is the site plus a signed offset that
// depends on the mode and on whether the site opens or closes its row.
// The result leaves as a magnitude and a sign for the wrap by site count.
module lpn_nbr_calc (
  input  logic                                        clk_i,
  input  logic                                        en_i,
  input  lpn_pkg::lpn_geom_t                          geom_i,
  input  lpn_pkg::lpn_site_sb_t                       site_i,
  input  logic [lpn_pkg::SIDE_W-1:0]                  rem_i,
  output logic [lpn_pkg::NBR_N-1:0][lpn_pkg::MAG_W-1:0] mag_o,
  output lpn_pkg::lpn_wrap_sb_t                       sb_o
);

  import lpn_pkg::*;

  logic                              row_last;
  logic                              row_first;
  logic [OFF_W-1:0]                  side_x;
  logic [OFF_W-1:0]                  one_x;
  logic [OFF_W-1:0]                  last_sub;
  logic [OFF_W-1:0]                  first_add;
  logic [NBR_N-1:0][OFF_W-1:0]       off;
  logic [NBR_N-1:0]                  lane_on;
  logic [NBR_N-1:0][RAW_W-1:0]       raw;
  logic [NBR_N-1:0][MAG_W-1:0]       mag_d;
  logic [NBR_N-1:0]                  neg_d;
  logic [NBR_N-1:0][MAG_W-1:0]       mag_q;
  lpn_wrap_sb_t                      sb_q;

  // Position of the site within its row.
  assign row_last  = (rem_i == (geom_i.side - SIDE_W'(1)));
  assign row_first = (rem_i == '0);
  assign side_x    = OFF_W'(geom_i.side);
  assign one_x     = OFF_W'(1);
  assign last_sub  = row_last ? side_x : '0;
  assign first_add = row_first ? side_x : '0;

  // Offsets in two's complement; wraps by whole volumes are left to the
  // remainder stage, which makes them vanish.
  always_comb begin
    off = '0;
    if (geom_i.tri_mode == MODE_TRI) begin
      off[0] = one_x - last_sub;
      off[1] = one_x - side_x - last_sub;
      off[2] = '0 - side_x;
      off[3] = first_add - one_x;
      off[4] = side_x - one_x + first_add;
      off[5] = side_x;
    end else begin
      off[0] = one_x - last_sub;
      off[1] = '0 - side_x;
      off[2] = first_add - one_x;
      off[3] = side_x;
    end
  end

  // Raw neighbor value, then sign and magnitude.
  always_comb begin
    for (int k = 0; k < NBR_N; k++) begin
      lane_on[k] = (k < NBR_SQ) || (geom_i.tri_mode == MODE_TRI);
      raw[k]     = lane_on[k]
                   ? (RAW_W'(site_i.site) + {{(RAW_W-OFF_W){off[k][OFF_W-1]}}, off[k]})
                   : '0;
      neg_d[k]   = raw[k][RAW_W-1];
      mag_d[k]   = neg_d[k] ? MAG_W'(RAW_W'(0) - raw[k]) : raw[k][MAG_W-1:0];
    end
  end

  // Stage register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q      <= mag_d;
      sb_q.err   <= site_i.err;
      sb_q.neg   <= neg_d;
    end
  end

  assign mag_o = mag_q;
  assign sb_o  = sb_q;

endmodule

`default_nettype wire

// File: sv/lpn_wrap_out.sv
`default_nettype none

// Output register: turns the remainder of a magnitude back into a residue
// of the signed value and clears every slot of an out-of-range site.
module lpn_wrap_out (
  input  logic                                          clk_i,
  input  logic                                          en_i,
  input  logic [lpn_pkg::SITES_W-1:0]                   sites_i,
  input  logic [lpn_pkg::NBR_N-1:0][lpn_pkg::SITES_W-1:0] rem_i,
  input  lpn_pkg::lpn_wrap_sb_t                         sb_i,
  output logic [lpn_pkg::NBR_N-1:0][lpn_pkg::IDX_W-1:0] nbr_o,
  output logic                                          err_o
);

  import lpn_pkg::*;

  logic [NBR_N-1:0][SITES_W-1:0] res;
  logic [NBR_N-1:0][IDX_W-1:0]   nbr_d;
  logic [NBR_N-1:0][IDX_W-1:0]   nbr_q;
  logic                          err_q;

  // A negative value with a nonzero remainder folds to count minus it.
  always_comb begin
    for (int k = 0; k < NBR_N; k++) begin
      res[k]   = (sb_i.neg[k] && (rem_i[k] != '0)) ? (sites_i - rem_i[k]) : rem_i[k];
      nbr_d[k] = sb_i.err ? '0 : res[k][IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nbr_q <= nbr_d;
      err_q <= sb_i.err;
    end
  end

  assign nbr_o = nbr_q;
  assign err_o = err_q;

endmodule

`default_nettype wire

// File: sim/tb_periodic_lattice_neighbors_core.sv
`timescale 1ns / 100ps

module tb_periodic_lattice_neighbors_core;
  import lpn_pkg::*;

  localparam int unsigned MAX_SIDE     = 256;
  localparam int unsigned MAX_SITES    = 65536;
  localparam int unsigned RANDOM_WORDS = 700;
  localparam longint unsigned RUN_LIMIT_NS = 5_000_000;

  // Neighbor indices of one site, slot 0 first, plus the out-of-range flag.
  typedef struct packed {
    logic [NBR_N-1:0][IDX_W-1:0] nbr;
    logic                        err;
  } neighbors_t;

  // One line of the directed stimulus: a register write or a site word,
  // the latter with an optional hand-written result.
  typedef struct packed {
    logic                 is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     value;
    logic                 typed;
    neighbors_t           result;
  } stim_row_t;

  localparam neighbors_t OUT_OF_RANGE = '{nbr: '0, err: 1'b1};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [IDX_W-1:0] site_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IDX_W-1:0] nbr_right, nbr_one, nbr_two, nbr_three, nbr_four, nbr_five;
  logic site_error;

  // Shadow copy of the block's registers.
  logic [SIDE_W-1:0]  side_reg  = SIDE_RST;
  logic [SITES_W-1:0] count_reg = SITES_RST;
  logic               mode_reg  = MODE_RST;

  neighbors_t expected_neighbors[$];
  stim_row_t  stim_table[$];

  bit failed = 1'b0;
  bit calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned words_sent = 0;
  int unsigned random_words = 0;
  int unsigned range_errors = 0;
  int unsigned tri_words = 0;
  int unsigned reg_settings = 0;
  int unsigned results_checked = 0;

  periodic_lattice_neighbors_core #(
    .MAX_SIDE (MAX_SIDE),
    .MAX_SITES(MAX_SITES)
  ) i_dut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .cfg_we_i             (cfg_we),
    .cfg_idx_i            (cfg_idx),
    .cfg_data_i           (cfg_data),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready),
    .site_index_i         (site_index),
    .out_valid_o          (out_valid),
    .out_ready_i          (out_ready),
    .neighbor_right_o     (nbr_right),
    .neighbor_slot_one_o  (nbr_one),
    .neighbor_slot_two_o  (nbr_two),
    .neighbor_slot_three_o(nbr_three),
    .neighbor_slot_four_o (nbr_four),
    .neighbor_slot_five_o (nbr_five),
    .site_error_o         (site_error)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Side length as the arithmetic sees it: zero counts as one, large values clip.
  function automatic int unsigned effective_side();
    int unsigned l;
    l = side_reg;
    if (l == 0) l = 1;
    if (l > MAX_SIDE) l = MAX_SIDE;
    return l;
  endfunction

  function automatic int unsigned effective_count();
    int unsigned v;
    v = count_reg;
    if (v > MAX_SITES) v = MAX_SITES;
    return v;
  endfunction

  // Neighbors of one site under the current shadow registers.
  function automatic neighbors_t lattice_neighbors(input logic [IDX_W-1:0] site);
    longint l, v, i;
    longint n[NBR_N];
    neighbors_t r;
    int k;
    l = effective_side();
    v = effective_count();
    i = site;
    r = '0;
    if (v == 0 || i >= v) begin
      r.err = 1'b1;
      return r;
    end
    for (k = 0; k < NBR_N; k++) n[k] = 0;
    if (mode_reg == MODE_SQUARE) begin
      n[0] = ((i + 1) % l == 0) ? i - l + 1 : i + 1;
      n[1] = (i < l) ? (v - l) + i : i - l;
      n[2] = (i % l == 0) ? i + l - 1 : i - 1;
      n[3] = (i >= v - l) ? i - (v - l) : i + l;
    end else begin
      n[0] = i + 1;
      n[1] = i - l + 1;
      n[2] = i - l;
      n[3] = i - 1;
      n[4] = i + l - 1;
      n[5] = i + l;
      if (n[1] < 0) n[1] += v;
      if (n[2] < 0) n[2] += v;
      if (n[4] >= v) n[4] -= v;
      if (n[5] >= v) n[5] -= v;
      // Last column: step back a row for the right-hand pair.
      if ((i + 1) % l == 0) begin
        n[0] -= l;
        n[1] -= l;
        if (i == l - 1) n[1] += v;
      end
      // First column: the left-hand pair comes from the row's far end.
      if (i % l == 0) begin
        n[3] = i + l - 1;
        n[4] += l;
        if (i >= v - l) n[4] -= v;
      end
    end
    // Fold every slot into the volume.
    for (k = 0; k < NBR_N; k++) begin
      n[k] = n[k] % v;
      if (n[k] < 0) n[k] += v;
      r.nbr[k] = IDX_W'(n[k]);
    end
    return r;
  endfunction

  function automatic neighbors_t square_result(input int unsigned right, input int unsigned up,
                                               input int unsigned left, input int unsigned down);
    neighbors_t r;
    r = '0;
    r.nbr[0] = IDX_W'(right);
    r.nbr[1] = IDX_W'(up);
    r.nbr[2] = IDX_W'(left);
    r.nbr[3] = IDX_W'(down);
    return r;
  endfunction

  // Length of the next idle stretch: mostly none, some short, a few long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Site words aimed at row ends, first and last rows, and out-of-range indexes, mixed with random ones.
  function automatic logic [IDX_W-1:0] pick_site();
    int unsigned l, v, r, rows, row, col, site;
    l = effective_side();
    v = effective_count();
    r = $urandom_range(0, 99);
    if (v == 0 || r < 12) return IDX_W'($urandom);
    if (r < 22) return (v > 65535) ? IDX_W'($urandom) : IDX_W'($urandom_range(v, 65535));
    if (r < 50) begin
      rows = (v - 1) / l;
      if ($urandom_range(0, 3) == 0) row = $urandom_range(0, 1) ? rows : 0;
      else row = $urandom_range(0, rows);
      col = $urandom_range(0, 1) ? l - 1 : 0;
      site = row * l + col;
      if (site >= v) site = v - 1;
      return IDX_W'(site);
    end
    return IDX_W'($urandom_range(0, v - 1));
  endfunction

  task automatic tbl_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    stim_row_t row;
    row = '0;
    row.is_reg = 1'b1;
    row.reg_idx = idx;
    row.value = value;
    stim_table.push_back(row);
  endtask

  task automatic tbl_site(input logic [IDX_W-1:0] site);
    stim_row_t row;
    row = '0;
    row.value = CFG_W'(site);
    stim_table.push_back(row);
  endtask

  task automatic tbl_typed(input logic [IDX_W-1:0] site, input neighbors_t result);
    stim_row_t row;
    row = '0;
    row.value = CFG_W'(site);
    row.typed = 1'b1;
    row.result = result;
    stim_table.push_back(row);
  endtask

  // Write one register; the enable is lowered by the next site word.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      CFG_SIDE_LENGTH:  side_reg = value[SIDE_W-1:0];
      CFG_SITE_COUNT:   count_reg = value[SITES_W-1:0];
      CFG_LATTICE_MODE: mode_reg = value[0];
      default: ;
    endcase
    reg_settings++;
  endtask

  // Stop sending and wait until every predicted word has come back. With
  // nothing pending the valid is already low and is left alone.
  task automatic drain_results();
    if (expected_neighbors.size() != 0) begin
      in_valid <= 1'b0;
      while (expected_neighbors.size() != 0) @(posedge clk);
    end
  endtask

  // Offer one site word and record its expected neighbors once accepted.
  task automatic send_site(input logic [IDX_W-1:0] site, input logic typed,
                           input neighbors_t result);
    int unsigned gap;
    neighbors_t want;
    gap = idle_len();
    cfg_we <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    want = typed ? result : lattice_neighbors(site);
    in_valid <= 1'b1;
    site_index <= site;
    do @(posedge clk); while (!in_ready);
    expected_neighbors.push_back(want);
    words_sent++;
    if (want.err) range_errors++;
    else if (mode_reg == MODE_TRI) tri_words++;
  endtask

  // Choose a lattice: mostly regular and small, some regular and large, some irregular, some at or beyond the limits.
  task automatic random_config();
    int unsigned pick;
    logic [SIDE_W-1:0] side;
    logic [SITES_W-1:0] count;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      side = SIDE_W'($urandom_range(1, 32));
      count = SITES_W'(side * $urandom_range(1, 32));
    end else if (pick < 70) begin
      side = SIDE_W'($urandom_range(1, 256));
      count = SITES_W'(side * $urandom_range(1, 256));
    end else if (pick < 85) begin
      side = SIDE_W'($urandom_range(1, 64));
      count = SITES_W'($urandom_range(1, 2000));
    end else if (pick < 95) begin
      case ($urandom_range(0, 3))
        0: side = '0;
        1: side = SIDE_W'(1);
        2: side = SIDE_W'(256);
        default: side = SIDE_W'($urandom_range(257, 511));
      endcase
      case ($urandom_range(0, 3))
        0: count = '0;
        1: count = SITES_W'(1);
        2: count = SITES_W'(65536);
        default: count = SITES_W'($urandom_range(65537, 131071));
      endcase
    end else begin
      side = SIDE_W'($urandom);
      count = SITES_W'($urandom);
    end
    write_reg(CFG_SIDE_LENGTH, CFG_W'(side));
    write_reg(CFG_SITE_COUNT, CFG_W'(count));
    write_reg(CFG_LATTICE_MODE, $urandom_range(0, 1) ? CFG_W'(MODE_TRI) : CFG_W'(MODE_SQUARE));
  endtask

  // Score each result word against the oldest prediction and pace the receiver.
  always @(posedge clk) begin : score_results
    neighbors_t got, want;
    int unsigned len;
    int k;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.nbr = {nbr_five, nbr_four, nbr_three, nbr_two, nbr_one, nbr_right};
        got.err = site_error;
        if (expected_neighbors.size() == 0) begin
          $display("%0t: result word with nothing pending (error flag %b)", $time, got.err);
          failed = 1'b1;
        end else begin
          want = expected_neighbors.pop_front();
          results_checked++;
          for (k = 0; k < NBR_N; k++) begin
            if (got.nbr[k] !== want.nbr[k]) begin
              $display("%0t: neighbor slot %0d expected %0d, got %0d",
                       $time, k, want.nbr[k], got.nbr[k]);
              failed = 1'b1;
            end
          end
          if (got.err !== want.err) begin
            $display("%0t: site error expected %b, got %b", $time, want.err, got.err);
            failed = 1'b1;
          end
        end
      end
      // Receiver stalls of random length.
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        len = idle_len();
        if (len > 0) begin
          stall_left <= len - 1;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("periodic_lattice_neighbors_core verification failed");
    $finish;
  end

  initial begin
    int unsigned phase_len;
    int unsigned j;

    // Reset defaults, then the volume edges and out-of-range sites.
    tbl_typed(16'd0, square_result(1, 240, 15, 16));
    tbl_typed(16'd255, square_result(240, 239, 254, 15));
    tbl_typed(16'd256, OUT_OF_RANGE);
    tbl_typed(16'hFFFF, OUT_OF_RANGE);
    tbl_site(16'd17);
    // Triangular corners and row ends.
    tbl_reg(CFG_LATTICE_MODE, CFG_W'(MODE_TRI));
    tbl_site(16'd0);
    tbl_site(16'd15);
    tbl_site(16'd240);
    tbl_site(16'd255);
    tbl_site(16'd100);
    // A zero side length acts as one.
    tbl_reg(CFG_SIDE_LENGTH, '0);
    tbl_reg(CFG_SITE_COUNT, 17'd5);
    tbl_site(16'd0);
    tbl_site(16'd4);
    tbl_typed(16'd5, OUT_OF_RANGE);
    // Oversized side length and site count clip to the maximum lattice.
    tbl_reg(CFG_SIDE_LENGTH, 17'd511);
    tbl_reg(CFG_SITE_COUNT, 17'h1FFFF);
    tbl_reg(CFG_LATTICE_MODE, CFG_W'(MODE_SQUARE));
    tbl_site(16'hFFFF);
    tbl_site(16'd0);
    tbl_site(16'd300);
    tbl_reg(CFG_LATTICE_MODE, CFG_W'(MODE_TRI));
    tbl_site(16'hFFFF);
    tbl_site(16'd255);
    tbl_site(16'd256);
    // An empty lattice flags every site.
    tbl_reg(CFG_SITE_COUNT, '0);
    tbl_typed(16'd0, OUT_OF_RANGE);
    // Largest regular lattice, square.
    tbl_reg(CFG_SIDE_LENGTH, 17'd256);
    tbl_reg(CFG_SITE_COUNT, 17'd65536);
    tbl_reg(CFG_LATTICE_MODE, CFG_W'(MODE_SQUARE));
    tbl_site(16'd0);
    tbl_site(16'hFFFF);
    // Site count not a multiple of the side length.
    tbl_reg(CFG_SIDE_LENGTH, 17'd7);
    tbl_reg(CFG_SITE_COUNT, 17'd50);
    tbl_reg(CFG_LATTICE_MODE, CFG_W'(MODE_TRI));
    tbl_site(16'd49);
    tbl_site(16'd6);
    tbl_site(16'd43);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part; registers change only with nothing in flight.
    foreach (stim_table[j]) begin
      if (stim_table[j].is_reg) begin
        drain_results();
        write_reg(stim_table[j].reg_idx, stim_table[j].value);
      end else begin
        send_site(stim_table[j].value[IDX_W-1:0], stim_table[j].typed,
                  stim_table[j].result);
      end
    end

    // Random part: one lattice per phase, some phases without any idling.
    while (random_words < RANDOM_WORDS) begin
      drain_results();
      random_config();
      calm = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 60);
      for (j = 0; j < phase_len; j++) begin
        if ($urandom_range(0, 59) == 0) drain_results();
        send_site(pick_site(), 1'b0, '0);
        random_words++;
      end
    end

    calm = 1'b0;
    drain_results();
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (expected_neighbors.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, expected_neighbors.size());
      failed = 1'b1;
    end

    $display("Sent %0d site words over %0d register writes; %0d results checked.",
             words_sent, reg_settings, results_checked);
    $display("Of these, %0d were flagged out of range and %0d used the triangular lattice.",
             range_errors, tri_words);
    if (!failed) begin
      $display("periodic_lattice_neighbors_core verification clean");
    end else begin
      $display("periodic_lattice_neighbors_core verification failed");
    end
    $finish;
  end

endmodule

// File: periodic_lattice_neighbors_core.f
+incdir+sv
sv/lpn_pkg.sv
sv/lpn_mod_pipe.sv
sv/lpn_nbr_calc.sv
sv/lpn_wrap_out.sv
sv/periodic_lattice_neighbors_core.sv
sim/tb_periodic_lattice_neighbors_core.sv
